// ----- rtl/core/rcmi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmi_pkg
// Shared types and constants for the row/column mean and invert block.
// ----------------------------------------------------------------------------
package rcmi_pkg;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 9;   // width of the dimension registers
  localparam int MEAN_W  = 16;  // 8.8 fixed point
  localparam int ROW_W   = 16;  // running row sum
  localparam int COL_W   = 16;  // column sum
  localparam int TOT_W   = 24;  // frame total
  localparam int DVD_W   = 32;  // divider numerator: frame total shifted by 8
  localparam int DVS_W   = 2 * DIM_W; // divider denominator: width * height

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_MEANS = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
    logic [7:0]       column_select;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PIX_W-1:0]  inverted_pixel;
    logic [7:0]        row_index;
    logic [MEAN_W-1:0] mean_value;
    logic [MEAN_W-1:0] image_mean;
    logic              frame_complete;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_ROW_DIV,
    ST_ROW_OUT,
    ST_RD_MEM,
    ST_COL_DIV,
    ST_IMG_DIV,
    ST_RD_OUT
  } state_t;

endpackage

// ----- rtl/core/image_row_column_mean_invert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_row_column_mean_invert
// Pixel inverter with running row, column and frame means.
// ----------------------------------------------------------------------------
// One request is handled at a time. A pixel push reads the column store
// when it is accepted in the idle state, then writes the sum back and loads
// the inverted pixel result in the push state once the output register is
// free. A push that ends a row then computes the row mean in the shared
// 32-step divider. A read runs a store read and two divisions (column mean,
// then frame mean) through the same divider. After reset the column store
// is swept to zero, one entry per cycle, over all MAX_DIM entries; no request
// is taken meanwhile, though register writes are. Results sit in an output
// register, so a new request may be accepted while the last result waits.
// ----------------------------------------------------------------------------
module image_row_column_mean_invert #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rcmi_pkg::req_t     req_data,
  output logic               res_valid,
  input  logic               res_ready,
  output rcmi_pkg::res_t     res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rcmi_pkg::*;

  localparam int AW = $clog2(MAX_DIM);

  // configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             cfg_wr;

  // frame state
  logic [ROW_W-1:0] row_accumulator;
  logic [TOT_W-1:0] frame_total;
  logic [AW-1:0]    current_row;
  logic [AW-1:0]    current_column;
  logic             frame_done_flag;

  // column store
  logic [COL_W-1:0] column_sums [MAX_DIM];
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [COL_W-1:0] mem_rdata;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [COL_W-1:0] mem_wr_data;
  logic [AW-1:0]    clr_addr;

  // sequencer
  state_t state;
  state_t state_next;
  logic   accept;
  logic   push_acc;
  logic   read_acc;
  logic   out_free;
  logic   load;
  res_t   load_data;

  // per-request hold registers
  logic [PIX_W-1:0]  px_q;
  logic [7:0]        row_q;
  logic [AW-1:0]     col_q;
  logic              first_row_q;
  logic              row_end_q;
  logic              done_q;
  logic [ROW_W-1:0]  acc_q;
  logic              sel_ok_q;
  logic [DVS_W-1:0]  wh_q;
  logic [MEAN_W-1:0] col_mean_q;

  // push arithmetic
  logic [ROW_W-1:0] acc_sum;
  logic [TOT_W-1:0] total_sum;
  logic             row_end;
  logic             last_row;
  logic             sel_ok;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-DIM_W){1'b0}}, image_height}
                                           : {{(32-DIM_W){1'b0}}, image_width};

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (image_width == '0)                 w_eff = DIM_W'(1);
    else if (32'(image_width) > MAX_DIM)   w_eff = DIM_W'(MAX_DIM);
    else                                   w_eff = image_width;
    if (image_height == '0)                h_eff = DIM_W'(1);
    else if (32'(image_height) > MAX_DIM)  h_eff = DIM_W'(MAX_DIM);
    else                                   h_eff = image_height;
  end

  // --------------------------------------------------------------------------
  // Push arithmetic
  // --------------------------------------------------------------------------
  assign accept   = req_valid && req_ready;
  assign push_acc = accept && (req_data.cmd == CMD_PUSH);
  assign read_acc = accept && (req_data.cmd == CMD_READ);

  assign acc_sum   = row_accumulator + {{(ROW_W-PIX_W){1'b0}}, req_data.pixel};
  assign total_sum = (frame_done_flag ? '0 : frame_total)
                     + {{(TOT_W-PIX_W){1'b0}}, req_data.pixel};
  assign row_end   = (32'(current_column) + 32'd1) >= 32'(w_eff);
  assign last_row  = (32'(current_row) + 32'd1) >= 32'(h_eff);
  assign sel_ok    = ({1'b0, req_data.column_select} < w_eff)
                     && (32'(req_data.column_select) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_RESET;
      image_height    <= DIM_RESET;
      row_accumulator <= '0;
      frame_total     <= '0;
      current_row     <= '0;
      current_column  <= '0;
      frame_done_flag <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEIGHT) image_height <= pwdata[DIM_W-1:0];
      else                        image_width  <= pwdata[DIM_W-1:0];
      // restart the frame, keep the column sums
      row_accumulator <= '0;
      frame_total     <= '0;
      current_row     <= '0;
      current_column  <= '0;
      frame_done_flag <= 1'b0;
    end else if (push_acc) begin
      frame_total <= total_sum;
      if (row_end) begin
        row_accumulator <= '0;
        current_column  <= '0;
        if (last_row) begin
          current_row     <= '0;
          frame_done_flag <= 1'b1;
        end else begin
          current_row     <= current_row + 1'b1;
          frame_done_flag <= 1'b0;
        end
      end else begin
        row_accumulator <= acc_sum;
        current_column  <= current_column + 1'b1;
        frame_done_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      px_q        <= req_data.pixel;
      row_q       <= 8'(current_row);
      col_q       <= current_column;
      first_row_q <= (current_row == '0);
      row_end_q   <= row_end;
      done_q      <= row_end && last_row;
      acc_q       <= acc_sum;
    end
    if (read_acc) begin
      sel_ok_q <= sel_ok;
      wh_q     <= w_eff * h_eff;
    end
    if (state == ST_COL_DIV && div_rsp.done) begin
      col_mean_q <= sel_ok_q ? div_rsp.quotient : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Column store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_rd_en) mem_rdata <= column_sums[mem_rd_addr];
    if (mem_wr_en) column_sums[mem_wr_addr] <= mem_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst)                   clr_addr <= '0;
    else if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next       = state;
    req_ready        = 1'b0;
    mem_rd_en        = accept;
    mem_rd_addr      = (req_data.cmd == CMD_READ) ? AW'(req_data.column_select)
                                                  : current_column;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = col_q;
    mem_wr_data      = first_row_q ? {{(COL_W-PIX_W){1'b0}}, px_q}
                                   : mem_rdata + {{(COL_W-PIX_W){1'b0}}, px_q};
    load             = 1'b0;
    load_data        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DVD_W-ROW_W-8){1'b0}}, acc_q, 8'h00};
    div_req.divisor  = {{(DVS_W-DIM_W){1'b0}}, w_eff};

    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
        if (clr_addr == AW'(MAX_DIM - 1)) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (accept) state_next = (req_data.cmd == CMD_READ) ? ST_RD_MEM : ST_PUSH;
      end

      ST_PUSH: begin
        if (out_free) begin
          mem_wr_en                = 1'b1;
          load                     = 1'b1;
          load_data.kind           = KIND_PIXEL;
          load_data.inverted_pixel = PIX_MAX - px_q;
          load_data.row_index      = row_q;
          load_data.frame_complete = done_q;
          load_data.last           = !row_end_q;
          if (row_end_q) begin
            div_req.start = 1'b1;
            state_next    = ST_ROW_DIV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_ROW_DIV: begin
        if (div_rsp.done) state_next = ST_ROW_OUT;
      end

      ST_ROW_OUT: begin
        if (out_free) begin
          load                     = 1'b1;
          load_data.kind           = KIND_ROW;
          load_data.row_index      = row_q;
          load_data.mean_value     = div_rsp.quotient;
          load_data.frame_complete = done_q;
          load_data.last           = 1'b1;
          state_next               = ST_IDLE;
        end
      end

      ST_RD_MEM: begin
        // divide every column read; an out-of-range select is zeroed after
        div_req.start    = 1'b1;
        div_req.dividend = {{(DVD_W-COL_W-8){1'b0}}, mem_rdata, 8'h00};
        div_req.divisor  = {{(DVS_W-DIM_W){1'b0}}, h_eff};
        state_next       = ST_COL_DIV;
      end

      ST_COL_DIV: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {frame_total, 8'h00};
          div_req.divisor  = wh_q;
          state_next       = ST_IMG_DIV;
        end
      end

      ST_IMG_DIV: begin
        if (div_rsp.done) state_next = ST_RD_OUT;
      end

      ST_RD_OUT: begin
        if (out_free) begin
          load                     = 1'b1;
          load_data.kind           = KIND_MEANS;
          load_data.mean_value     = col_mean_q;
          load_data.image_mean     = div_rsp.quotient;
          load_data.frame_complete = frame_done_flag;
          load_data.last           = 1'b1;
          state_next               = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  rcmi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst)            res_valid <= 1'b0;
    else if (load)      res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) res_data <= load_data;
  end

endmodule

// ----- rtl/core/rcmi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmi_div
// Radix-2 restoring divider, one quotient bit per cycle, result saturated
// to the 8.8 mean range.
// ----------------------------------------------------------------------------
module rcmi_div (
  input  logic                clk,
  input  logic                rst,
  input  rcmi_pkg::div_req_t  req,
  output rcmi_pkg::div_rsp_t  rsp
);
  import rcmi_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic             done;
  logic [MEAN_W-1:0] quot;

  logic [DVS_W:0]   shifted;
  logic             take;
  logic [DVS_W:0]   diff;
  logic [DVD_W-1:0] dvd_next;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, dvd[DVD_W-1]};
    take     = (shifted >= {1'b0, dvs});
    diff     = shifted - {1'b0, dvs};
    dvd_next = {dvd[DVD_W-2:0], take};
    rem_next = take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
      if (cnt == CNT_W'(DVD_W - 1)) begin
        // saturate anything above the 8.8 range
        quot <= (|dvd_next[DVD_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : dvd_next[MEAN_W-1:0];
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// ----- rtl/core/rcmi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmi_checker
// Port-level checks for the row/column mean and invert block.
// ----------------------------------------------------------------------------
module rcmi_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           res_valid,
  input logic           res_ready,
  input rcmi_pkg::res_t res_data
);
  import rcmi_pkg::*;

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed or dropped");

  // one request at a time: drop ready straight after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in work");

  // the column store sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !req_ready)
    else $error("request taken during the clearing pass");

  // a pixel result carries no means
  a_pixel_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == KIND_PIXEL
      |-> res_data.mean_value == '0 && res_data.image_mean == '0)
    else $error("pixel result with a mean field set");

  // row and means results close their request
  a_mean_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == KIND_ROW || res_data.kind == KIND_MEANS)
      |-> res_data.last && res_data.inverted_pixel == '0)
    else $error("mean result not marked last");

endmodule

bind image_row_column_mean_invert rcmi_checker u_rcmi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the row/column mean and pixel invert block.
// ----------------------------------------------------------------------------
// Pixel and read requests go in over a valid/ready channel. Each accepted
// request runs through a local model of the row, column and frame sums. That
// model queues the results the block should return. Every returned result is
// checked field by field against the oldest queued one. A short directed part
// covers reset state, degenerate and oversize dimensions, saturation and frame
// restart. Random phases then run whole and broken frames under varied
// dimensions, with bursty idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rcmi_pkg::*;

  localparam int ITEM_TARGET   = 850;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 100;
  localparam int STALL_LIMIT   = 3000;
  localparam int NUM_COLS      = 256;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req_data;
  logic        res_valid;
  logic        res_ready;
  res_t        res_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the block state
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [15:0]      row_sum;
  logic [15:0]      col_sum [NUM_COLS];
  logic [23:0]      frame_sum;
  int unsigned      pos_row;
  int unsigned      pos_col;
  logic             frame_done;

  res_t stats_due[$];
  res_t due;
  int   fail_count;
  int   items_sent;
  int   idle_cycles;
  int   req_gap_pct;
  int   res_stall_pct;
  bit   quiet;
  bit   hold_off_req;

  image_row_column_mean_invert u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the sums and means
  // --------------------------------------------------------------------------
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > NUM_COLS) return NUM_COLS;
    return v;
  endfunction

  function automatic logic [15:0] mean_8p8(input longint unsigned sum,
                                           input longint unsigned count);
    longint unsigned q;
    if (count == 0) return '0;
    q = (sum << 8) / count;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void restart_frame();
    row_sum    = '0;
    frame_sum  = '0;
    pos_row    = 0;
    pos_col    = 0;
    frame_done = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_width  = DIM_RESET;
    cfg_height = DIM_RESET;
    for (int i = 0; i < NUM_COLS; i++) col_sum[i] = '0;
    restart_frame();
  endfunction

  task automatic predict_pixel_stats(input req_t r);
    int unsigned w;
    int unsigned h;
    int unsigned row;
    int unsigned col;
    int unsigned sel;
    logic [15:0] row_mean;
    res_t        o;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    o = '0;
    if (r.cmd == CMD_READ) begin
      sel          = r.column_select;
      o.kind       = KIND_MEANS;
      o.mean_value = (sel < w) ? mean_8p8(col_sum[sel], h) : '0;
      o.image_mean = mean_8p8(frame_sum, longint'(w) * h);
      o.frame_complete = frame_done;
      o.last       = 1'b1;
      stats_due.push_back(o);
    end else begin
      row = pos_row;
      col = (pos_col >= NUM_COLS) ? NUM_COLS - 1 : pos_col;
      // a push after a finished frame opens a new one
      if (frame_done) begin
        frame_done = 1'b0;
        frame_sum  = '0;
      end
      row_sum   = row_sum + r.pixel;
      col_sum[col] = (row == 0) ? 16'(r.pixel) : col_sum[col] + r.pixel;
      frame_sum = frame_sum + r.pixel;
      o.kind           = KIND_PIXEL;
      o.inverted_pixel = PIX_MAX - r.pixel;
      o.row_index      = row[7:0];
      if (col + 1 < w) begin
        pos_col          = col + 1;
        o.frame_complete = frame_done;
        o.last           = 1'b1;
        stats_due.push_back(o);
      end else begin
        row_mean = mean_8p8(row_sum, w);
        row_sum  = '0;
        pos_col  = 0;
        if (row + 1 >= h) begin
          pos_row    = 0;
          frame_done = 1'b1;
        end else begin
          pos_row = row + 1;
        end
        o.frame_complete = frame_done;
        o.last           = 1'b0;
        stats_due.push_back(o);
        o                = '0;
        o.kind           = KIND_ROW;
        o.row_index      = row[7:0];
        o.mean_value     = row_mean;
        o.frame_complete = frame_done;
        o.last           = 1'b1;
        stats_due.push_back(o);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Call on a falling edge; returns on a falling edge with valid left high
  // unless a gap was inserted.
  task automatic send_req(input req_t r);
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_pixel_stats(r);
    items_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(1, 100) <= req_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return PIX_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_push(input logic [7:0] px);
    req_t r;
    r.cmd           = CMD_PUSH;
    r.pixel         = px;
    r.column_select = 8'($urandom_range(0, 255));
    send_req(r);
  endtask

  task automatic send_read(input logic [7:0] sel);
    req_t r;
    r.cmd           = CMD_READ;
    r.pixel         = 8'($urandom_range(0, 255));
    r.column_select = sel;
    send_req(r);
  endtask

  // Drop valid and hold until every queued result is back.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (stats_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dimension(input logic idx, input int raw);
    logic [31:0] data;
    data = $urandom();
    if ($urandom_range(0, 1) == 0) data = '0;
    data[8:0] = raw[8:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = data[8:0];
    else cfg_height = data[8:0];
    restart_frame();
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  initial begin : res_side
    int stall_left;
    stall_left = 0;
    res_ready  = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stall_left > 0) begin
          stall_left--;
        end else if (!quiet && $urandom_range(1, 100) <= res_stall_pct) begin
          res_ready <= 1'b0;
          stall_left = $urandom_range(0, 7);
        end else begin
          res_ready <= 1'b1;
        end
        @(negedge clk);
      end
    end
  end

  task automatic show_result(input string tag, input res_t r);
    $display("  %s kind=%0d inv=%0d row=%0d mean=%h img=%h done=%0b last=%0b",
             tag, r.kind, r.inverted_pixel, r.row_index, r.mean_value,
             r.image_mean, r.frame_complete, r.last);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (stats_due.size() == 0) begin
        if (fail_count < 10) begin
          $display("[%0t] result with nothing outstanding", $realtime);
          show_result("got", res_data);
        end
        fail_count++;
      end else begin
        due = stats_due.pop_front();
        if (res_data.kind !== due.kind ||
            res_data.inverted_pixel !== due.inverted_pixel ||
            res_data.row_index !== due.row_index ||
            res_data.mean_value !== due.mean_value ||
            res_data.image_mean !== due.image_mean ||
            res_data.frame_complete !== due.frame_complete ||
            res_data.last !== due.last) begin
          if (fail_count < 10) begin
            $display("[%0t] result mismatch", $realtime);
            show_result("exp", due);
            show_result("got", res_data);
          end
          fail_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_after_reset();
    send_read(8'd0);
    send_read(8'd255);
    send_push(PIX_MAX);
    send_push(8'd0);
    send_read(8'd0);
    wait_idle();
  endtask

  // zero dimensions act as one; height drop without a push saturates
  task automatic test_degenerate_dims();
    write_dimension(REG_WIDTH, 0);
    write_dimension(REG_HEIGHT, 2);
    send_push(PIX_MAX);
    send_push(PIX_MAX);
    send_read(8'd0);
    send_read(8'd1);
    wait_idle();
    write_dimension(REG_HEIGHT, 0);
    send_read(8'd0);
    send_push(8'd0);
    send_read(8'd0);
    send_push(8'd17);
    send_read(8'd0);
    wait_idle();
  endtask

  // register values past the maximum clamp to it
  task automatic test_oversize_dims();
    write_dimension(REG_WIDTH, 511);
    write_dimension(REG_HEIGHT, 300);
    send_push(PIX_MAX);
    send_push(8'd0);
    send_push(8'h5A);
    send_read(8'd255);
    send_read(8'd1);
    send_read(8'd200);
    wait_idle();
  endtask

  task automatic run_pixels(input int count, input int unsigned w);
    int unsigned top;
    top = (w > NUM_COLS) ? NUM_COLS - 1 : w - 1;
    for (int i = 0; i < count; i++) begin
      // no idling over the tail of the run
      quiet = (items_sent >= ITEM_TARGET - 120);
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 9) < 7) send_read(8'($urandom_range(0, top)));
        else send_read(8'($urandom_range(0, 255)));
      end
      send_push(rand_pixel());
    end
  endtask

  task automatic test_random_frames();
    int          phase;
    int          raw_w;
    int          raw_h;
    int          frames;
    int          pushes;
    int unsigned w;
    int unsigned h;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      req_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
      res_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      frames        = $urandom_range(1, 3);
      if (phase == 1) begin
        raw_w  = $urandom_range(0, 1) ? 511 : 256;
        raw_h  = $urandom_range(1, 2);
        frames = 1;
      end else if (phase == 3) begin
        raw_w  = $urandom_range(0, 1);
        raw_h  = 256;
        frames = 1;
      end else begin
        raw_w = $urandom_range(0, 12);
        raw_h = $urandom_range(0, 6);
      end
      if (phase <= 3 || $urandom_range(0, 3) != 0) write_dimension(REG_WIDTH, raw_w);
      if (phase <= 3 || $urandom_range(0, 3) != 0) write_dimension(REG_HEIGHT, raw_h);
      w      = eff_dim(cfg_width);
      h      = eff_dim(cfg_height);
      pushes = frames * w * h;
      // leave a broken frame behind now and then
      if (phase != 1 && phase != 3 && $urandom_range(0, 3) == 0)
        pushes += $urandom_range(1, w * h);
      // hold the output off during a full-width row so the input backs up
      if (phase == 1) begin
        @(posedge clk);
        hold_off_req = 1'b1;
        @(negedge clk);
      end
      run_pixels(pushes, w);
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_data      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    req_gap_pct   = 20;
    res_stall_pct = 20;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_degenerate_dims();
    test_oversize_dims();
    test_random_frames();

    while (stats_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && stats_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rcmi_pkg.sv
rtl/core/rcmi_div.sv
rtl/core/image_row_column_mean_invert.sv
rtl/core/rcmi_checker.sv
test/tb_top.sv
